### hw/rtl/beat_energy_detector_macros.svh
// ----------------------------------------------------------------------------
// beat_energy_detector_macros
// assertion macros of the beat energy detector rtl, used in bed_ctrl
// ----------------------------------------------------------------------------
`ifndef BEAT_ENERGY_DETECTOR_MACROS_SVH
`define BEAT_ENERGY_DETECTOR_MACROS_SVH

// property that must hold at every clock edge outside reset
`define BED_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define BED_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/bed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bed_pkg
// types and constants of the beat energy detector
// ----------------------------------------------------------------------------
package bed_pkg;

	// frame format
	localparam int BANDS       = 7;
	localparam int SAMPLE_BITS = 10;
	localparam int SUM_W       = SAMPLE_BITS + $clog2(BANDS);
	localparam int CNT_W       = $clog2(BANDS + 1);

	// history depth default
	localparam int HISTORY_DEF = 32;

	// state widths
	localparam int WSUM_W = 32;
	localparam int WCNT_W = 16;

	// register field widths
	localparam int MIN_W  = 20;
	localparam int FACT_W = 10;
	localparam int LVL_W  = 8;

	// shared unit multiplier operand width
	localparam int MB_W = 16;

	// configuration port
	localparam int NUM_REGS = 7;
	localparam int ADDR_W   = $clog2(NUM_REGS * 4);
	localparam int DATA_W   = 32;
	localparam int IDX_W    = ADDR_W - 2;

	localparam logic [IDX_W-1:0] REG_BAND_MASK     = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_MIN_ENERGY    = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_DIM_FACTOR    = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_BRIGHT_FACTOR = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_OFF_LEVEL     = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_DIM_LEVEL     = IDX_W'(5);
	localparam logic [IDX_W-1:0] REG_BRIGHT_LEVEL  = IDX_W'(6);

	// register reset values
	localparam logic [BANDS-1:0]  RST_BAND_MASK     = BANDS'(127);
	localparam logic [MIN_W-1:0]  RST_MIN_ENERGY    = MIN_W'(144);
	localparam logic [FACT_W-1:0] RST_DIM_FACTOR    = FACT_W'(307);
	localparam logic [FACT_W-1:0] RST_BRIGHT_FACTOR = FACT_W'(333);
	localparam logic [LVL_W-1:0]  RST_OFF_LEVEL     = LVL_W'(0);
	localparam logic [LVL_W-1:0]  RST_DIM_LEVEL     = LVL_W'(64);
	localparam logic [LVL_W-1:0]  RST_BRIGHT_LEVEL  = LVL_W'(255);

	// configuration seen by the datapath
	typedef struct packed {
		logic [BANDS-1:0]  band_mask;
		logic [MIN_W-1:0]  min_energy;
		logic [FACT_W-1:0] dim_factor;
		logic [FACT_W-1:0] bright_factor;
		logic [LVL_W-1:0]  off_level;
		logic [LVL_W-1:0]  dim_level;
		logic [LVL_W-1:0]  bright_level;
	} cfg_t;

	// beat classes
	typedef enum logic [1:0] {
		CLS_OFF    = 2'd0,
		CLS_DIM    = 2'd1,
		CLS_BRIGHT = 2'd2
	} class_t;

	// shared unit operations
	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_sts_t;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV_GO,
		S_DIV_WAIT,
		S_ACC,
		S_LHS_GO,
		S_LHS_WAIT,
		S_DIM_GO,
		S_DIM_WAIT,
		S_BRT_GO,
		S_BRT_WAIT,
		S_MIN_GO,
		S_MIN_WAIT,
		S_EMIT
	} state_t;

endpackage

### hw/rtl/bed_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bed_in_if
// frame channel: band levels and end-of-beat flag
// ----------------------------------------------------------------------------
interface bed_in_if;
	logic                             valid;
	logic                             ready;
	logic [bed_pkg::SAMPLE_BITS-1:0]  band0;
	logic [bed_pkg::SAMPLE_BITS-1:0]  band1;
	logic [bed_pkg::SAMPLE_BITS-1:0]  band2;
	logic [bed_pkg::SAMPLE_BITS-1:0]  band3;
	logic [bed_pkg::SAMPLE_BITS-1:0]  band4;
	logic [bed_pkg::SAMPLE_BITS-1:0]  band5;
	logic [bed_pkg::SAMPLE_BITS-1:0]  band6;
	logic                             end_beat;

	modport source (
		output valid, band0, band1, band2, band3, band4, band5, band6, end_beat,
		input  ready
	);
	modport sink (
		input  valid, band0, band1, band2, band3, band4, band5, band6, end_beat,
		output ready
	);
endinterface

### hw/rtl/bed_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bed_out_if
// result channel: light level, class and change flag
// ----------------------------------------------------------------------------
interface bed_out_if;
	logic                       valid;
	logic                       ready;
	logic [bed_pkg::LVL_W-1:0]  light_level;
	logic [1:0]                 beat_class;
	logic                       level_changed;

	modport source (
		output valid, light_level, beat_class, level_changed,
		input  ready
	);
	modport sink (
		input  valid, light_level, beat_class, level_changed,
		output ready
	);
endinterface

### hw/rtl/beat_energy_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beat_energy_detector
// energy history beat detector: classes each beat window as off, dim or bright
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  frame     in   valid / ready    band0..band6, end_beat
//  result    out  valid / ready    light_level, beat_class, level_changed
//  apb       in   psel / penable   paddr, pwdata, prdata (pready tied high)
//
//  a frame without end_beat runs the band average divide, one bit per cycle
//  in the shared unit (13 steps), plus sequencing
//  an end_beat frame adds four shift-add passes by a multiplier b,
//  b being HISTORY, dim_factor, bright_factor and the window frame count,
//  and then loads the result register
//  frame.ready is high only while the sequencer is idle
//  a result waits in the output register; the next one stalls until it is taken
//  reset clears window, history valid bits and history total at once
module beat_energy_detector #(
	parameter int HISTORY = bed_pkg::HISTORY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	bed_in_if.sink                      frame,
	bed_out_if.source                   result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bed_pkg::ADDR_W-1:0]  paddr,
	input  logic [bed_pkg::DATA_W-1:0]  pwdata,
	output logic [bed_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	localparam int PW = bed_pkg::WSUM_W + $clog2(HISTORY) + bed_pkg::FACT_W;

	bed_pkg::cfg_t             cfg;
	bed_pkg::alu_ctl_t         alu_ctl;
	bed_pkg::alu_sts_t         alu_sts;
	logic [PW-1:0]             alu_a;
	logic [PW-1:0]             alu_acc;
	logic [bed_pkg::MB_W-1:0]  alu_b;
	logic [bed_pkg::MB_W-1:0]  alu_quo;

	// configuration registers
	bed_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// shared multiply / divide unit
	bed_alu #(
		.PW (PW)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (alu_ctl),
		.a      (alu_a),
		.b      (alu_b),
		.sts    (alu_sts),
		.acc    (alu_acc),
		.quo    (alu_quo)
	);

	// sequencer and state
	bed_ctrl #(
		.HISTORY (HISTORY)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.frame   (frame),
		.result  (result),
		.cfg     (cfg),
		.alu_ctl (alu_ctl),
		.alu_a   (alu_a),
		.alu_b   (alu_b),
		.alu_sts (alu_sts),
		.alu_acc (alu_acc),
		.alu_quo (alu_quo)
	);

endmodule

### hw/rtl/bed_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bed_regs
// apb configuration registers of the beat energy detector
// ----------------------------------------------------------------------------
module bed_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bed_pkg::ADDR_W-1:0]  paddr,
	input  logic [bed_pkg::DATA_W-1:0]  pwdata,
	output logic [bed_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output bed_pkg::cfg_t               cfg
);

	bed_pkg::cfg_t                   cfg_q;
	logic [bed_pkg::IDX_W-1:0]       idx;
	logic                            wr_en;

	assign idx    = paddr[bed_pkg::ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band_mask     <= bed_pkg::RST_BAND_MASK;
			cfg_q.min_energy    <= bed_pkg::RST_MIN_ENERGY;
			cfg_q.dim_factor    <= bed_pkg::RST_DIM_FACTOR;
			cfg_q.bright_factor <= bed_pkg::RST_BRIGHT_FACTOR;
			cfg_q.off_level     <= bed_pkg::RST_OFF_LEVEL;
			cfg_q.dim_level     <= bed_pkg::RST_DIM_LEVEL;
			cfg_q.bright_level  <= bed_pkg::RST_BRIGHT_LEVEL;
		end else if (wr_en) begin
			unique case (idx)
				bed_pkg::REG_BAND_MASK: begin
					cfg_q.band_mask <= pwdata[bed_pkg::BANDS-1:0];
				end
				bed_pkg::REG_MIN_ENERGY: begin
					cfg_q.min_energy <= pwdata[bed_pkg::MIN_W-1:0];
				end
				bed_pkg::REG_DIM_FACTOR: begin
					cfg_q.dim_factor <= pwdata[bed_pkg::FACT_W-1:0];
				end
				bed_pkg::REG_BRIGHT_FACTOR: begin
					cfg_q.bright_factor <= pwdata[bed_pkg::FACT_W-1:0];
				end
				bed_pkg::REG_OFF_LEVEL: begin
					cfg_q.off_level <= pwdata[bed_pkg::LVL_W-1:0];
				end
				bed_pkg::REG_DIM_LEVEL: begin
					cfg_q.dim_level <= pwdata[bed_pkg::LVL_W-1:0];
				end
				bed_pkg::REG_BRIGHT_LEVEL: begin
					cfg_q.bright_level <= pwdata[bed_pkg::LVL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// register read
	always_comb begin
		unique case (idx)
			bed_pkg::REG_BAND_MASK:     prdata = bed_pkg::DATA_W'(cfg_q.band_mask);
			bed_pkg::REG_MIN_ENERGY:    prdata = bed_pkg::DATA_W'(cfg_q.min_energy);
			bed_pkg::REG_DIM_FACTOR:    prdata = bed_pkg::DATA_W'(cfg_q.dim_factor);
			bed_pkg::REG_BRIGHT_FACTOR: prdata = bed_pkg::DATA_W'(cfg_q.bright_factor);
			bed_pkg::REG_OFF_LEVEL:     prdata = bed_pkg::DATA_W'(cfg_q.off_level);
			bed_pkg::REG_DIM_LEVEL:     prdata = bed_pkg::DATA_W'(cfg_q.dim_level);
			bed_pkg::REG_BRIGHT_LEVEL:  prdata = bed_pkg::DATA_W'(cfg_q.bright_level);
			default:                    prdata = '0;
		endcase
	end

endmodule

### hw/rtl/bed_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bed_alu
// shared shift-add multiplier and restoring divider, one bit per cycle
// ----------------------------------------------------------------------------
module bed_alu #(
	parameter int PW = bed_pkg::WSUM_W + $clog2(bed_pkg::HISTORY_DEF) + bed_pkg::FACT_W
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bed_pkg::alu_ctl_t         ctl,
	input  logic [PW-1:0]             a,
	input  logic [bed_pkg::MB_W-1:0]  b,
	output bed_pkg::alu_sts_t         sts,
	output logic [PW-1:0]             acc,
	output logic [bed_pkg::MB_W-1:0]  quo
);

	localparam int STEP_W = $clog2(bed_pkg::SUM_W + 1);

	bed_pkg::alu_op_t          op_q;
	logic                      busy_q;
	logic                      done_q;
	logic [STEP_W-1:0]         cnt_q;
	logic [PW-1:0]             a_q;
	logic [PW-1:0]             acc_q;
	logic [bed_pkg::MB_W-1:0]  b_q;

	logic                      is_mul;
	logic [PW-1:0]             addend;
	logic [PW:0]               sum;
	logic                      fin;

	// one adder serves both: add for multiply, subtract with carry out for divide
	assign is_mul = (op_q == bed_pkg::OP_MUL);
	assign addend = is_mul ? a_q : ~a_q;
	assign sum    = {1'b0, acc_q} + {1'b0, addend} + {{PW{1'b0}}, !is_mul};
	assign fin    = is_mul ? (b_q == '0) : (cnt_q == '0);

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign acc      = acc_q;
	assign quo      = b_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= bed_pkg::OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				op_q   <= ctl.op;
			end else if (busy_q && fin) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// operand and result registers
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			if (ctl.op == bed_pkg::OP_MUL) begin
				a_q   <= a;
				b_q   <= b;
				acc_q <= '0;
			end else begin
				a_q   <= PW'(b) << (bed_pkg::SUM_W - 1);
				b_q   <= '0;
				acc_q <= a;
				cnt_q <= STEP_W'(bed_pkg::SUM_W);
			end
		end else if (busy_q && !fin) begin
			if (is_mul) begin
				if (b_q[0]) begin
					acc_q <= sum[PW-1:0];
				end
				a_q <= a_q << 1;
				b_q <= b_q >> 1;
			end else begin
				if (sum[PW]) begin
					acc_q <= sum[PW-1:0];
				end
				b_q   <= {b_q[bed_pkg::MB_W-2:0], sum[PW]};
				a_q   <= a_q >> 1;
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/bed_ctrl.sv
`timescale 1ns / 1ps
`include "beat_energy_detector_macros.svh"
// ----------------------------------------------------------------------------
// bed_ctrl
// sequencer, window and history state, history memory and result register
// ----------------------------------------------------------------------------
module bed_ctrl #(
	parameter int HISTORY = bed_pkg::HISTORY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	bed_in_if.sink              frame,
	bed_out_if.source           result,
	input  bed_pkg::cfg_t       cfg,
	output bed_pkg::alu_ctl_t   alu_ctl,
	output logic [bed_pkg::WSUM_W+$clog2(HISTORY)+bed_pkg::FACT_W-1:0] alu_a,
	output logic [bed_pkg::MB_W-1:0] alu_b,
	input  bed_pkg::alu_sts_t   alu_sts,
	input  logic [bed_pkg::WSUM_W+$clog2(HISTORY)+bed_pkg::FACT_W-1:0] alu_acc,
	input  logic [bed_pkg::MB_W-1:0] alu_quo
);

	localparam int HIDX_W = $clog2(HISTORY);
	localparam int TOT_W  = bed_pkg::WSUM_W + HIDX_W;
	localparam int PW     = TOT_W + bed_pkg::FACT_W;
	localparam int WS_W   = bed_pkg::WSUM_W;
	localparam int WC_W   = bed_pkg::WCNT_W;

	bed_pkg::state_t                  state_q, state_d;

	// frame capture
	logic [bed_pkg::SAMPLE_BITS-1:0]  band [bed_pkg::BANDS];
	logic [bed_pkg::SUM_W-1:0]        fsum;
	logic [bed_pkg::CNT_W-1:0]        fcnt;
	logic [bed_pkg::SUM_W-1:0]        sum_q;
	logic [bed_pkg::CNT_W-1:0]        n_q;
	logic                             end_q;

	// window and history state
	logic [WS_W-1:0]                  ws_q;
	logic [WC_W-1:0]                  wc_q;
	logic [TOT_W-1:0]                 total_q;
	logic [HIDX_W-1:0]                oldest_q;
	bed_pkg::class_t                  shown_q;
	logic [HISTORY-1:0]               valid_q;
	logic [WS_W-1:0]                  ring [HISTORY];
	logic [WS_W-1:0]                  rd_q;

	// compare results
	logic [PW-1:0]                    lhs_q;
	logic                             dim_hit_q;
	logic                             brt_hit_q;
	logic                             enough_q;

	// result register
	logic                             out_valid_q;
	logic [bed_pkg::LVL_W-1:0]        out_level_q;
	bed_pkg::class_t                  out_cls_q;
	logic                             out_chg_q;

	logic                             accept;
	logic                             emit_ok;
	logic                             emit_fire;
	logic [bed_pkg::SUM_W-1:0]        energy;
	logic [WS_W:0]                    ws_sum;
	bed_pkg::class_t                  cls;
	logic [bed_pkg::LVL_W-1:0]        level;
	logic [WS_W-1:0]                  old_val;

	assign band[0] = frame.band0;
	assign band[1] = frame.band1;
	assign band[2] = frame.band2;
	assign band[3] = frame.band3;
	assign band[4] = frame.band4;
	assign band[5] = frame.band5;
	assign band[6] = frame.band6;

	// masked band sum and band count
	always_comb begin
		fsum = '0;
		fcnt = '0;
		for (int i = 0; i < bed_pkg::BANDS; i++) begin
			if (cfg.band_mask[i]) begin
				fsum = fsum + bed_pkg::SUM_W'(band[i]);
				fcnt = fcnt + bed_pkg::CNT_W'(1);
			end
		end
	end

	assign accept    = frame.valid && frame.ready;
	assign emit_ok   = !out_valid_q || result.ready;
	assign emit_fire = (state_q == bed_pkg::S_EMIT) && emit_ok;
	assign energy    = (n_q == '0) ? '0 : alu_quo[bed_pkg::SUM_W-1:0];
	assign ws_sum    = {1'b0, ws_q} + (WS_W + 1)'(energy);
	assign old_val   = valid_q[oldest_q] ? rd_q : '0;

	// classification
	always_comb begin
		cls = bed_pkg::CLS_OFF;
		if (dim_hit_q && enough_q) begin
			cls = brt_hit_q ? bed_pkg::CLS_BRIGHT : bed_pkg::CLS_DIM;
		end
		case (cls)
			bed_pkg::CLS_BRIGHT: level = cfg.bright_level;
			bed_pkg::CLS_DIM:    level = cfg.dim_level;
			default:             level = cfg.off_level;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bed_pkg::S_IDLE:     if (accept) state_d = bed_pkg::S_DIV_GO;
			bed_pkg::S_DIV_GO:   state_d = bed_pkg::S_DIV_WAIT;
			bed_pkg::S_DIV_WAIT: if (alu_sts.done) state_d = bed_pkg::S_ACC;
			bed_pkg::S_ACC:      state_d = end_q ? bed_pkg::S_LHS_GO : bed_pkg::S_IDLE;
			bed_pkg::S_LHS_GO:   state_d = bed_pkg::S_LHS_WAIT;
			bed_pkg::S_LHS_WAIT: if (alu_sts.done) state_d = bed_pkg::S_DIM_GO;
			bed_pkg::S_DIM_GO:   state_d = bed_pkg::S_DIM_WAIT;
			bed_pkg::S_DIM_WAIT: if (alu_sts.done) state_d = bed_pkg::S_BRT_GO;
			bed_pkg::S_BRT_GO:   state_d = bed_pkg::S_BRT_WAIT;
			bed_pkg::S_BRT_WAIT: if (alu_sts.done) state_d = bed_pkg::S_MIN_GO;
			bed_pkg::S_MIN_GO:   state_d = bed_pkg::S_MIN_WAIT;
			bed_pkg::S_MIN_WAIT: if (alu_sts.done) state_d = bed_pkg::S_EMIT;
			bed_pkg::S_EMIT:     if (emit_ok) state_d = bed_pkg::S_IDLE;
			default:             state_d = bed_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		frame.ready   = (state_q == bed_pkg::S_IDLE);
		alu_ctl.start = 1'b0;
		alu_ctl.op    = bed_pkg::OP_MUL;
		alu_a         = '0;
		alu_b         = '0;
		unique case (state_q)
			bed_pkg::S_DIV_GO: begin
				alu_ctl.start = 1'b1;
				alu_ctl.op    = bed_pkg::OP_DIV;
				alu_a         = PW'(sum_q);
				alu_b         = bed_pkg::MB_W'(n_q);
			end
			bed_pkg::S_LHS_GO: begin
				alu_ctl.start = 1'b1;
				alu_a         = PW'(ws_q);
				alu_b         = bed_pkg::MB_W'(HISTORY);
			end
			bed_pkg::S_DIM_GO: begin
				alu_ctl.start = 1'b1;
				alu_a         = PW'(total_q);
				alu_b         = bed_pkg::MB_W'(cfg.dim_factor);
			end
			bed_pkg::S_BRT_GO: begin
				alu_ctl.start = 1'b1;
				alu_a         = PW'(total_q);
				alu_b         = bed_pkg::MB_W'(cfg.bright_factor);
			end
			bed_pkg::S_MIN_GO: begin
				alu_ctl.start = 1'b1;
				alu_a         = PW'(cfg.min_energy);
				alu_b         = bed_pkg::MB_W'(wc_q);
			end
			default: begin
			end
		endcase
	end

	assign result.valid         = out_valid_q;
	assign result.light_level   = out_level_q;
	assign result.beat_class    = out_cls_q;
	assign result.level_changed = out_chg_q;

	// control state, window and history bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bed_pkg::S_IDLE;
			ws_q        <= '0;
			wc_q        <= '0;
			total_q     <= '0;
			oldest_q    <= '0;
			shown_q     <= bed_pkg::CLS_OFF;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bed_pkg::S_ACC) begin
				ws_q <= ws_sum[WS_W] ? '1 : ws_sum[WS_W-1:0];
				if (wc_q != '1) begin
					wc_q <= wc_q + 1'b1;
				end
			end
			if (emit_fire) begin
				shown_q           <= cls;
				total_q           <= total_q + TOT_W'(ws_q) - TOT_W'(old_val);
				valid_q[oldest_q] <= 1'b1;
				oldest_q          <= (oldest_q == HIDX_W'(HISTORY - 1)) ? '0 : oldest_q + 1'b1;
				ws_q              <= '0;
				wc_q              <= '0;
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sum_q <= fsum;
			n_q   <= fcnt;
			end_q <= frame.end_beat;
		end
		if (state_q == bed_pkg::S_LHS_WAIT && alu_sts.done) begin
			lhs_q <= {alu_acc[PW-9:0], 8'd0};
		end
		if (state_q == bed_pkg::S_DIM_WAIT && alu_sts.done) begin
			dim_hit_q <= (lhs_q > alu_acc);
		end
		if (state_q == bed_pkg::S_BRT_WAIT && alu_sts.done) begin
			brt_hit_q <= (lhs_q > alu_acc);
		end
		if (state_q == bed_pkg::S_MIN_WAIT && alu_sts.done) begin
			enough_q <= (PW'(ws_q) >= alu_acc);
		end
		if (emit_fire) begin
			out_level_q <= level;
			out_cls_q   <= cls;
			out_chg_q   <= (cls != shown_q);
		end
	end

	// history memory: oldest entry read at frame accept, replaced at result
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			ring[oldest_q] <= ws_q;
		end
		if (accept) begin
			rd_q <= ring[oldest_q];
		end
	end

	// checks
	`BED_ASSERT(a_alu_idle_start, !(alu_ctl.start && alu_sts.busy),
		"shared unit started while busy")
	`BED_ASSERT_NEXT(a_window_cleared, emit_fire,
		(wc_q == '0) && (ws_q == '0) && (state_q == bed_pkg::S_IDLE),
		"window not cleared after result")
	`BED_ASSERT(a_empty_history, (valid_q != '0) || (total_q == '0),
		"history total nonzero with empty history")
	`BED_ASSERT(a_slot_range, oldest_q <= HIDX_W'(HISTORY - 1),
		"oldest slot out of range")

endmodule
